// ----- src/cprc_pkg.sv -----
// cprc_pkg: shared constants and types for the color patch range calibrator.
// No dependencies; used by the interfaces, the channel lane and the top level.
package cprc_pkg;

   localparam int HIST_BINS = 256;
   localparam int BIN_W     = $clog2(HIST_BINS);
   localparam int LEN_W     = $clog2(HIST_BINS + 1);
   localparam int PIX_W     = 8;
   localparam int HIGH_W    = 9;

   // sequencer to lane controls
   typedef struct packed {
      logic             set_en;    // pixel transaction accepted, mark its bin
      logic             clr_en;    // write zero at clr_addr
      logic [BIN_W-1:0] clr_addr;
      logic [BIN_W-1:0] rd_addr;
      logic             start;     // reset run trackers
      logic             step;      // read data valid, advance the run tracker
      logic [BIN_W-1:0] step_bin;  // bin index of the read data
   } lane_ctl_type;

endpackage

// ----- src/cprc_if.sv -----
// cprc_req_if / cprc_rsp_if: valid/ready channels of the range calibrator.
// Depends on cprc_pkg for field widths.
interface cprc_req_if;
   logic                      valid;
   logic                      ready;
   logic [cprc_pkg::PIX_W-1:0] first_channel;
   logic [cprc_pkg::PIX_W-1:0] second_channel;
   logic [cprc_pkg::PIX_W-1:0] third_channel;
   logic                      last_pixel;

   modport source (output valid, first_channel, second_channel, third_channel, last_pixel,
                   input ready);
   modport sink (input valid, first_channel, second_channel, third_channel, last_pixel,
                 output ready);
endinterface

interface cprc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cprc_pkg::PIX_W-1:0]  first_low;
   logic [cprc_pkg::HIGH_W-1:0] first_high;
   logic [cprc_pkg::PIX_W-1:0]  second_low;
   logic [cprc_pkg::PIX_W-1:0]  third_low;

   modport source (output valid, first_low, first_high, second_low, third_low,
                   input ready);
   modport sink (input valid, first_low, first_high, second_low, third_low,
                 output ready);
endinterface

// ----- src/cprc_lane.sv -----
// cprc_lane: one channel's occupancy map (HIST_BINS x 1 memory) and run tracker.
// Depends on cprc_pkg; driven by the sequencer in the top level.
module cprc_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  cprc_pkg::lane_ctl_type        ctl,
   input  logic [cprc_pkg::PIX_W-1:0]    pix,
   output logic [cprc_pkg::BIN_W-1:0]    best_start,
   output logic [cprc_pkg::LEN_W-1:0]    best_len
);

   logic                       map_mem [cprc_pkg::HIST_BINS];
   logic                       rd_data_ff;
   logic                       in_range;
   logic                       wr_en;
   logic [cprc_pkg::BIN_W-1:0] wr_addr;

   logic [cprc_pkg::LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [cprc_pkg::BIN_W-1:0] cur_start_ff, cur_start_in;
   logic [cprc_pkg::LEN_W-1:0] best_len_ff, best_len_in;
   logic [cprc_pkg::BIN_W-1:0] best_start_ff, best_start_in;
   logic                       gap_ff, gap_in;
   logic                       longer;

   // values beyond the map are dropped
   assign in_range = ({1'b0, pix} < (cprc_pkg::PIX_W + 1)'(cprc_pkg::HIST_BINS));
   assign wr_en    = ctl.clr_en | (ctl.set_en & in_range);
   assign wr_addr  = ctl.clr_en ? ctl.clr_addr : pix[cprc_pkg::BIN_W-1:0];

   // read returns the old contents when the same bin is cleared in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= ~ctl.clr_en;
      end
      rd_data_ff <= map_mem[ctl.rd_addr];
   end

   assign longer = (cur_len_ff > best_len_ff);

   always_comb begin
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      gap_in        = gap_ff;
      if (ctl.start) begin
         cur_len_in    = '0;
         cur_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
         gap_in        = 1'b0;
      end else if (ctl.step) begin
         if (!rd_data_ff) begin
            if (!gap_ff) begin
               gap_in = 1'b1;
            end else begin
               // second empty bin in a row closes the run
               if (longer) begin
                  best_len_in   = cur_len_ff;
                  best_start_in = cur_start_ff;
               end
               cur_len_in = '0;
            end
         end else begin
            if (cur_len_ff == '0) begin
               cur_start_in = ctl.step_bin;
            end
            gap_in     = 1'b0;
            cur_len_in = cur_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff    <= '0;
         cur_start_ff  <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         gap_ff        <= 1'b0;
      end else begin
         cur_len_ff    <= cur_len_in;
         cur_start_ff  <= cur_start_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         gap_ff        <= gap_in;
      end
   end

   // the run still open at the top of the map competes too
   assign best_start = longer ? cur_start_ff : best_start_ff;
   assign best_len   = longer ? cur_len_ff : best_len_ff;

endmodule

// ----- src/color_patch_range_calibrator_top.sv -----
// color_patch_range_calibrator_top: pixel intake, end-of-patch scan sequencer,
// result register. Depends on cprc_pkg, cprc_if and cprc_lane.
// Throughput: one pixel per cycle while loading; a pixel marked last starts a scan
// of all HIST_BINS bins, one bin of all three maps per cycle (one memory read port
// per map), and the result shows once the scan, tail and output states have passed.
// Reset: a clearing pass over all HIST_BINS bins zeroes the maps; no pixel is taken then.
module color_patch_range_calibrator_top (
   input logic       clock,
   input logic       reset,
   cprc_req_if.sink  req_chan,
   cprc_rsp_if.source rsp_chan
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [cprc_pkg::BIN_W-1:0] LAST_BIN = cprc_pkg::BIN_W'(cprc_pkg::HIST_BINS - 1);

   logic [2:0]                 state_ff, state_in;
   logic [cprc_pkg::BIN_W-1:0] cnt_ff, cnt_in;
   logic                       rd_valid_ff;
   logic [cprc_pkg::BIN_W-1:0] rd_bin_ff;
   logic                       accept;
   logic                       out_free;
   cprc_pkg::lane_ctl_type     ctl;

   logic [cprc_pkg::BIN_W-1:0] start0, start1, start2;
   logic [cprc_pkg::LEN_W-1:0] len0, len1, len2;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cprc_pkg::PIX_W-1:0]  first_low_ff, second_low_ff, third_low_ff;
   logic [cprc_pkg::HIGH_W-1:0] first_high_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_chan.last_pixel) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIN) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      ctl.set_en   = accept;
      ctl.clr_en   = (state_ff == ST_CLEAR) | (state_ff == ST_SCAN);
      ctl.clr_addr = cnt_ff;
      ctl.rd_addr  = cnt_ff;
      ctl.start    = accept & req_chan.last_pixel;
      ctl.step     = rd_valid_ff;
      ctl.step_bin = rd_bin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      rd_bin_ff <= cnt_ff;
   end

   cprc_lane u_lane0 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .pix        (req_chan.first_channel),
      .best_start (start0),
      .best_len   (len0)
   );

   cprc_lane u_lane1 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .pix        (req_chan.second_channel),
      .best_start (start1),
      .best_len   (len1)
   );

   cprc_lane u_lane2 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .pix        (req_chan.third_channel),
      .best_start (start2),
      .best_len   (len2)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         first_low_ff  <= cprc_pkg::PIX_W'(start0);
         first_high_ff <= cprc_pkg::HIGH_W'(cprc_pkg::HIGH_W'(start0) +
                                            cprc_pkg::HIGH_W'(len0));
         second_low_ff <= cprc_pkg::PIX_W'(start1);
         third_low_ff  <= cprc_pkg::PIX_W'(start2);
      end
   end

   // second and third lengths are not reported; no upper bound is given for them
   logic unused_len;
   assign unused_len = ^{len1, len2};

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.first_low  = first_low_ff;
   assign rsp_chan.first_high = first_high_ff;
   assign rsp_chan.second_low = second_low_ff;
   assign rsp_chan.third_low  = third_low_ff;

endmodule
